// File: rtl/eot_pkg.sv
// Shared types, order codes and the order merge function for the elevator order table.
package eot_pkg;

    localparam int FLOORS  = 4;
    localparam int FLOOR_W = 2;
    localparam int ORD_W   = 3;

    typedef logic [ORD_W-1:0] ord_t;
    typedef ord_t [FLOORS-1:0] table_t;

    localparam ord_t ORD_NONE = 3'd0;
    localparam ord_t ORD_UP   = 3'd1;
    localparam ord_t ORD_DOWN = 3'd2;
    localparam ord_t ORD_BOTH = 3'd3;
    localparam ord_t ORD_CAB  = 3'd4;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    localparam logic [1:0] DIR_DOWN = 2'd0;
    localparam logic [1:0] DIR_STOP = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FLOOR_W-1:0] floor;
        logic [1:0]         button;
        logic [1:0]         direction;
        logic [FLOOR_W-1:0] last_floor;
    } item_t;

    // Merges a new button press into a stored order code.
    function automatic ord_t merge_order(input ord_t cur, input logic [1:0] btn);
        ord_t res;
        res = cur;
        if (cur != ORD_CAB) begin
            case (btn)
                BTN_CAB:  res = ORD_CAB;
                BTN_UP:   res = (cur == ORD_NONE || cur == ORD_UP) ? ORD_UP : ORD_BOTH;
                BTN_DOWN: res = (cur == ORD_NONE || cur == ORD_DOWN) ? ORD_DOWN : ORD_BOTH;
                default:  res = cur;
            endcase
        end
        return res;
    endfunction

endpackage

// File: rtl/eot_table.sv
// Order table storage with the add, remove and clear update.
module eot_table (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            update_en,
    input  eot_pkg::item_t  item,
    output eot_pkg::table_t table_next
);
    import eot_pkg::*;

    table_t table_reg;

    always_comb begin
        table_next = table_reg;
        case (item.action)
            ACT_ADD:    table_next[item.floor] = merge_order(table_reg[item.floor], item.button);
            ACT_REMOVE: table_next[item.floor] = ORD_NONE;
            ACT_CLEAR:  table_next = '0;
            default:    table_next = table_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_reg <= '0;
        end else if (update_en) begin
            table_reg <= table_next;
        end
    end

endmodule

// File: rtl/eot_select.sv
// Nearest eligible floor selection over the updated order table.
module eot_select (
    input  eot_pkg::table_t               orders,
    input  logic [1:0]                    direction,
    input  logic [eot_pkg::FLOOR_W-1:0]   last_floor,
    output logic                          found,
    output logic [eot_pkg::FLOOR_W-1:0]   destination
);
    import eot_pkg::*;

    logic [FLOOR_W-1:0] idx;
    logic [FLOOR_W-1:0] floor_dist;
    logic [FLOOR_W-1:0] best_dist;
    logic               eligible;

    always_comb begin
        found       = 1'b0;
        destination = '0;
        best_dist   = '0;
        idx         = '0;
        floor_dist  = '0;
        eligible    = 1'b0;
        for (int i = 0; i < FLOORS; i++) begin
            idx        = FLOOR_W'(i);
            eligible   = (orders[i] != ORD_NONE)
                         && !(orders[i] == ORD_UP && direction == DIR_DOWN)
                         && !(orders[i] == ORD_DOWN && direction == DIR_UP);
            floor_dist = (idx >= last_floor) ? (idx - last_floor) : (last_floor - idx);
            if (eligible && (!found || floor_dist < best_dist)) begin
                found       = 1'b1;
                destination = idx;
                best_dist   = floor_dist;
            end
        end
    end

endmodule

// File: rtl/elevator_order_table.sv
// Top level of the elevator order table with input and result registers.
// An accepted transaction is held in the input register until the result register can take it;
// its result is then loaded into the result register, which raises m_valid.
// One transaction is accepted per cycle while m_ready keeps the result register free; the table
// update and nearest-floor select lie between the two registers.
// Synchronous active-low reset empties both registers and sets every floor to no order.
module elevator_order_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [eot_pkg::FLOOR_W-1:0] s_floor,
    input  logic [1:0]                  s_button,
    input  logic [1:0]                  s_direction,
    input  logic [eot_pkg::FLOOR_W-1:0] s_last_floor,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [eot_pkg::FLOOR_W-1:0] m_destination
);
    import eot_pkg::*;

    item_t              item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               found_reg;
    logic [FLOOR_W-1:0] dest_reg;
    logic               advance;
    table_t             table_next;
    logic               sel_found;
    logic [FLOOR_W-1:0] sel_dest;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{action: s_action, floor: s_floor, button: s_button,
                          direction: s_direction, last_floor: s_last_floor};
        end
    end

    eot_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update_en  (advance),
        .item       (item_reg),
        .table_next (table_next)
    );

    eot_select u_select (
        .orders      (table_next),
        .direction   (item_reg.direction),
        .last_floor  (item_reg.last_floor),
        .found       (sel_found),
        .destination (sel_dest)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            found_reg <= sel_found;
            dest_reg  <= sel_dest;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = found_reg;
    assign m_destination = dest_reg;

    a_adv_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Processed transaction did not reach the result register.");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("Input register empty but s_ready is low.");

    a_none_dest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_destination == '0))
        else $error("Destination is nonzero although no floor was found.");

endmodule
